>>> hdl/orthonormal_color_transform_defines.svh
// Assertion helpers used by the RTL in orthonormal_color_transform.sv.
`ifndef ORTHONORMAL_COLOR_TRANSFORM_DEFINES_SVH
`define ORTHONORMAL_COLOR_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oct assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("oct assertion failed");

`endif

>>> hdl/oct_pkg.sv
package oct_pkg;

    localparam int SAMPLE_BITS = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 2;
    localparam int CHANNELS = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t sample_a;
        sample_t sample_b;
        sample_t sample_c;
        sample_t sample_d;
    } pixel_in_t;

    typedef struct packed {
        sample_t result_a;
        sample_t result_b;
        sample_t result_c;
        sample_t result_d;
        logic    saturated;
    } pixel_out_t;

    // One finished channel: clipped value plus clip flag.
    typedef struct packed {
        sample_t value;
        logic    clipped;
    } rs_out_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DIRECTION    = 2'd0,
        CFG_CHANNEL_MODE = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_RGB    = 2'd1,
        MODE_BAYER  = 2'd2
    } mode_t;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    // Integer square root, elaboration-time use only (coefficient setup).
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = x;
        root = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (bitv > x) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return root;
    endfunction

endpackage

>>> hdl/oct_round_sat.sv
module oct_round_sat #(
    parameter int PAIR_BITS = 40,
    parameter int FRAC_BITS = 16
) (
    input  logic signed [PAIR_BITS-1:0] pair_lo,
    input  logic signed [PAIR_BITS-1:0] pair_hi,
    output oct_pkg::rs_out_t            res
);
    import oct_pkg::*;

    localparam int SUM_BITS = PAIR_BITS + 2;
    localparam int Q_BITS   = SUM_BITS - FRAC_BITS;
    localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [Q_BITS-1:0] Q_MAX = Q_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] Q_MIN = -Q_MAX - Q_BITS'(1);

    logic signed [SUM_BITS-1:0] sum;
    logic signed [Q_BITS-1:0]   q;

    // Add the half LSB, then floor: round to nearest, ties up.
    assign sum = SUM_BITS'(pair_lo) + SUM_BITS'(pair_hi) + HALF;
    assign q   = $signed(sum[SUM_BITS-1:FRAC_BITS]);

    always_comb begin
        if (q > Q_MAX) begin
            res.value   = Q_MAX[SAMPLE_BITS-1:0];
            res.clipped = 1'b1;
        end else if (q < Q_MIN) begin
            res.value   = Q_MIN[SAMPLE_BITS-1:0];
            res.clipped = 1'b1;
        end else begin
            res.value   = q[SAMPLE_BITS-1:0];
            res.clipped = 1'b0;
        end
    end

endmodule

>>> hdl/orthonormal_color_transform.sv
// Orthonormal color transform, one pixel per request.
// Input channel s_valid/s_ready/s_data carries up to four signed samples
// (6 fraction bits); result channel m_valid/m_ready/m_data returns the four
// transformed channels and a saturated flag. cfg_valid/cfg_ready with
// cfg_index/cfg_data writes direction (index 0) and channel_mode (index 1);
// other indexes are dropped. cfg_ready is always high; write config only
// while the pipeline is empty.
// Pipeline: input register, coefficient multiply, pair add, final add with
// round and saturate into the output register. Throughput is one pixel per
// cycle while m_ready stays high.
// Each stage advances when it is empty or the stage after it moves, so a
// stall at m_ready backs the stages up one at a time without dropping or
// duplicating a request; s_ready falls only once all four stages are full.
// Reset (aresetn low, synchronous) empties the pipeline and sets direction
// forward and channel_mode three-channel RGB.
// Mode code 3 behaves as single-channel passthrough; unused outputs are zero.
`include "orthonormal_color_transform_defines.svh"

module orthonormal_color_transform #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  oct_pkg::pixel_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output oct_pkg::pixel_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [oct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [oct_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import oct_pkg::*;

    // Coefficient width: signed, room for the unity gain used by passthrough.
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = SAMPLE_BITS + CW;       // product
    localparam int AW = PW + 1;                 // pair sum

    // round(sqrt(n/d) * 2^F): sqrt of n/d scaled by 2^(2F+2), then halve.
    localparam longint unsigned SCALE = 64'd1 << (2 * (COEF_FRAC_BITS + 1));
    localparam longint unsigned KA_U = (isqrt(SCALE / 3) + 64'd1) >> 1;
    localparam longint unsigned KB_U = (isqrt(SCALE / 2) + 64'd1) >> 1;
    localparam longint unsigned KQ_U = (isqrt(SCALE / 6) + 64'd1) >> 1;
    localparam longint unsigned KC_U = (isqrt((2 * SCALE) / 3) + 64'd1) >> 1;

    localparam logic signed [CW-1:0] KA   = CW'(KA_U);  // 1/sqrt3
    localparam logic signed [CW-1:0] KB   = CW'(KB_U);  // 1/sqrt2
    localparam logic signed [CW-1:0] KQ   = CW'(KQ_U);  // 1/sqrt6
    localparam logic signed [CW-1:0] KC   = CW'(KC_U);  // sqrt(2/3)
    localparam logic signed [CW-1:0] KH   = CW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] KONE = CW'(1) <<< COEF_FRAC_BITS;
    localparam logic signed [CW-1:0] KZ   = '0;

    // Config registers.
    logic       dir_reg;
    logic [1:0] mode_reg;

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic en1, en2, en3, en4;

    // Stage 1: captured pixel plus the config it runs under.
    logic       v1_reg;
    sample_t    samp_reg [CHANNELS];
    logic       dir1_reg;
    logic [1:0] mode1_reg;

    // Stage 2: products, [output][input].
    logic                   v2_reg;
    logic signed [CW-1:0]   coef [CHANNELS][CHANNELS];
    logic signed [PW-1:0]   prod_next [CHANNELS][CHANNELS];
    logic signed [PW-1:0]   prod_reg  [CHANNELS][CHANNELS];

    // Stage 3: two partial sums per output.
    logic                   v3_reg;
    logic signed [AW-1:0]   pair_next [CHANNELS][2];
    logic signed [AW-1:0]   pair_reg  [CHANNELS][2];

    // Stage 4: rounded, saturated result in the output register.
    logic                   m_valid_reg;
    pixel_out_t             m_data_reg;
    pixel_out_t             m_data_next;
    rs_out_t                rs [CHANNELS];

    assign en4 = !m_valid_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready   = en1;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Config writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= DIR_FORWARD;
            mode_reg <= MODE_RGB;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DIRECTION:    dir_reg  <= cfg_data[0];
                CFG_CHANNEL_MODE: mode_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) m_valid_reg <= v3_reg;
        end
    end

    // Stage 1 capture.
    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            samp_reg[0] <= s_data.sample_a;
            samp_reg[1] <= s_data.sample_b;
            samp_reg[2] <= s_data.sample_c;
            samp_reg[3] <= s_data.sample_d;
            dir1_reg    <= dir_reg;
            mode1_reg   <= mode_reg;
        end
    end

    // Coefficient matrix, row = output channel, column = input channel.
    // Inverse matrices are the transposes of the forward ones.
    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            for (int i = 0; i < CHANNELS; i++) begin
                coef[j][i] = KZ;
            end
        end
        case (mode1_reg)
            MODE_RGB: begin
                if (dir1_reg == DIR_FORWARD) begin
                    coef[0][0] = KA;  coef[0][1] = KA;  coef[0][2] = KA;
                    coef[1][0] = KB;  coef[1][2] = -KB;
                    coef[2][0] = KQ;  coef[2][1] = -KC; coef[2][2] = KQ;
                end else begin
                    coef[0][0] = KA;  coef[0][1] = KB;  coef[0][2] = KQ;
                    coef[1][0] = KA;  coef[1][2] = -KC;
                    coef[2][0] = KA;  coef[2][1] = -KB; coef[2][2] = KQ;
                end
            end
            MODE_BAYER: begin
                if (dir1_reg == DIR_FORWARD) begin
                    coef[0][0] = KH;  coef[0][1] = KH;  coef[0][2] = KH;  coef[0][3] = KH;
                    coef[1][1] = KB;  coef[1][2] = -KB;
                    coef[2][0] = -KH; coef[2][1] = KH;  coef[2][2] = KH;  coef[2][3] = -KH;
                    coef[3][0] = -KB; coef[3][3] = KB;
                end else begin
                    coef[0][0] = KH;  coef[0][2] = -KH; coef[0][3] = -KB;
                    coef[1][0] = KH;  coef[1][1] = KB;  coef[1][2] = KH;
                    coef[2][0] = KH;  coef[2][1] = -KB; coef[2][2] = KH;
                    coef[3][0] = KH;  coef[3][2] = -KH; coef[3][3] = KB;
                end
            end
            default: begin
                // single channel and the unused code: unity on channel 0
                coef[0][0] = KONE;
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            for (int i = 0; i < CHANNELS; i++) begin
                prod_next[j][i] = PW'(coef[j][i]) * PW'(samp_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 3: pairwise sums.
    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            pair_next[j][0] = AW'(prod_reg[j][0]) + AW'(prod_reg[j][1]);
            pair_next[j][1] = AW'(prod_reg[j][2]) + AW'(prod_reg[j][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            pair_reg <= pair_next;
        end
    end

    // Stage 4: final add, round, saturate.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_fin
        oct_round_sat #(
            .PAIR_BITS (AW),
            .FRAC_BITS (COEF_FRAC_BITS)
        ) u_round_sat (
            .pair_lo (pair_reg[g][0]),
            .pair_hi (pair_reg[g][1]),
            .res     (rs[g])
        );
    end

    always_comb begin
        m_data_next.result_a  = rs[0].value;
        m_data_next.result_b  = rs[1].value;
        m_data_next.result_c  = rs[2].value;
        m_data_next.result_d  = rs[3].value;
        m_data_next.saturated = rs[0].clipped || rs[1].clipped
                             || rs[2].clipped || rs[3].clipped;
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    // A clip always leaves at least one channel on a rail.
    `OCT_ASSERT_NOW(a_sat_on_rail, aclk, aresetn,
        m_valid_reg && m_data_reg.saturated,
        (m_data_reg.result_a == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
        || (m_data_reg.result_a == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
        || (m_data_reg.result_b == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
        || (m_data_reg.result_b == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
        || (m_data_reg.result_c == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
        || (m_data_reg.result_c == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
        || (m_data_reg.result_d == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
        || (m_data_reg.result_d == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))

    // Back-pressure reaches the input only with every stage occupied.
    `OCT_ASSERT_NOW(a_full_when_blocked, aclk, aresetn,
        !s_ready,
        v1_reg && v2_reg && v3_reg && m_valid_reg)

    // A held stage keeps its item and its data.
    `OCT_ASSERT_NEXT(a_stage3_hold, aclk, aresetn,
        v3_reg && !en3,
        v3_reg && $stable(pair_reg[0][0]) && $stable(pair_reg[3][1]))

endmodule

>>> test/orthonormal_color_transform_tb.sv
`timescale 1ns / 100ps

module orthonormal_color_transform_tb;
    import oct_pkg::*;

    localparam int COEF_FRAC_BITS   = 16;
    localparam int PIPE_LATENCY     = 3;      // accepting edge to m_valid
    localparam int MAX_IDLE         = 8;      // per-request gap / stall, cycles
    localparam int LONG_HOLD_CYCLES = 64;     // receiver hold-off, fills the pipe
    localparam int CORNER_COUNT     = 24;     // 4 corner pixels x 6 settings
    localparam int RANDOM_PIXELS    = 1400;
    localparam int REPORT_LIMIT     = 10;
    localparam int TIMEOUT_NS       = 2_000_000;

    // Codes the package has no name for.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Directed settings: every mode code, both directions.
    localparam logic CORNER_DIRS [6] = '{DIR_FORWARD, DIR_INVERSE, DIR_FORWARD,
                                         DIR_INVERSE, DIR_INVERSE, DIR_FORWARD};
    localparam logic [1:0] CORNER_MODES [6] = '{MODE_RGB, MODE_RGB, MODE_BAYER,
                                                MODE_BAYER, MODE_SINGLE, MODE_UNUSED};

    // Scoreboard: predicts each accepted pixel, checks results in order.
    class color_scoreboard;
        logic       direction;
        logic [1:0] channel_mode;
        longint     k_third;       // 1/sqrt3
        longint     k_half_root;   // 1/sqrt2
        longint     k_sixth;       // 1/sqrt6
        longint     k_two_thirds;  // sqrt(2/3)
        longint     k_half;        // 1/2
        pixel_out_t expected_pixels[$];
        int         checked;
        int         clipped;
        int         failures;

        function new();
            k_third      = scaled_root(1, 3);
            k_half_root  = scaled_root(1, 2);
            k_sixth      = scaled_root(1, 6);
            k_two_thirds = scaled_root(2, 3);
            k_half       = longint'(1) << (COEF_FRAC_BITS - 1);
            direction    = DIR_FORWARD;
            channel_mode = MODE_RGB;
            checked      = 0;
            clipped      = 0;
            failures     = 0;
        endfunction

        // round(sqrt(num/den) * 2^COEF_FRAC_BITS): floor root with one guard
        // bit by bisection, then round the guard bit away
        function longint scaled_root(longint num, longint den);
            longint target;
            longint lo;
            longint hi;
            longint mid;
            target = (num << (2 * (COEF_FRAC_BITS + 1))) / den;
            lo = 0;
            hi = longint'(1) << 24;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid <= target) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            return (lo + 1) >>> 1;
        endfunction

        // round half up, dropping the 16 coefficient fraction bits, then clip to the sample range
        function sample_t round_clip(longint acc, inout logic clip);
            longint q;
            longint top;
            top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            q = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (q > top) begin
                q = top;
                clip = 1'b1;
            end else if (q < -top - 1) begin
                q = -top - 1;
                clip = 1'b1;
            end
            return sample_t'(q);
        endfunction

        function void apply_register(logic [CFG_INDEX_BITS-1:0] index,
                                     logic [CFG_DATA_BITS-1:0] value);
            case (index)
                CFG_DIRECTION: begin
                    direction = value[0];
                end
                CFG_CHANNEL_MODE: begin
                    channel_mode = value;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_pixel(pixel_in_t px);
            longint     a;
            longint     b;
            longint     c;
            longint     d;
            pixel_out_t y;
            logic       clip;
            a = px.sample_a;
            b = px.sample_b;
            c = px.sample_c;
            d = px.sample_d;
            y = '0;
            clip = 1'b0;
            case (channel_mode)
                MODE_RGB: begin
                    if (direction == DIR_FORWARD) begin
                        y.result_a = round_clip(k_third * (a + b + c), clip);
                        y.result_b = round_clip(k_half_root * (a - c), clip);
                        y.result_c = round_clip(k_sixth * (a + c) - k_two_thirds * b, clip);
                    end else begin
                        y.result_a = round_clip(k_third * a + k_half_root * b
                                                + k_sixth * c, clip);
                        y.result_b = round_clip(k_third * a - k_two_thirds * c, clip);
                        y.result_c = round_clip(k_third * a - k_half_root * b
                                                + k_sixth * c, clip);
                    end
                end
                MODE_BAYER: begin
                    if (direction == DIR_FORWARD) begin
                        y.result_a = round_clip(k_half * (a + b + c + d), clip);
                        y.result_b = round_clip(k_half_root * (b - c), clip);
                        y.result_c = round_clip(k_half * (b + c - a - d), clip);
                        y.result_d = round_clip(k_half_root * (d - a), clip);
                    end else begin
                        y.result_a = round_clip(k_half * (a - c) - k_half_root * d, clip);
                        y.result_b = round_clip(k_half * (a + c) + k_half_root * b, clip);
                        y.result_c = round_clip(k_half * (a + c) - k_half_root * b, clip);
                        y.result_d = round_clip(k_half * (a - c) + k_half_root * d, clip);
                    end
                end
                default: begin
                    // single channel and the unused code: sample 0 straight through
                    y.result_a = px.sample_a;
                end
            endcase
            y.saturated = clip;
            expected_pixels.push_back(y);
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t want;
            checked++;
            if (got.saturated) begin
                clipped++;
            end
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result %0d arrived with nothing pending: %h", checked, got);
                end
                return;
            end
            want = expected_pixels.pop_front();
            if (got.result_a !== want.result_a || got.result_b !== want.result_b ||
                got.result_c !== want.result_c || got.result_d !== want.result_d ||
                got.saturated !== want.saturated) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result %0d mismatch, dir %0b mode %0d", checked,
                             direction, channel_mode);
                    $display("  expected a=%0d b=%0d c=%0d d=%0d sat=%0b", want.result_a,
                             want.result_b, want.result_c, want.result_d, want.saturated);
                    $display("  actual   a=%0d b=%0d c=%0d d=%0d sat=%0b", got.result_a,
                             got.result_b, got.result_c, got.result_d, got.saturated);
                end
            end
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    pixel_in_t                 s_data;
    logic                      m_valid;
    logic                      m_ready;
    pixel_out_t                m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Per-phase knobs set by the main flow for the sender and the receiver.
    bit gaps_on;
    bit stalls_on;
    bit hold_off_request;

    int              pixels_sent;
    int              settings_used;
    pixel_in_t       corner_pixels [4];
    color_scoreboard board;

    orthonormal_color_transform #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly full-range values, with small values and values at or near the
    // rails mixed in so that rounding and clipping both get exercised.
    function automatic sample_t random_sample();
        int pick;
        int near;
        pick = $urandom_range(0, 9);
        near = int'($urandom_range(0, 255));
        if (pick < 6) begin
            return sample_t'($urandom);
        end
        if (pick < 8) begin
            return sample_t'(int'($urandom_range(0, 2047)) - 1024);
        end
        if (pick == 8) begin
            return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        end
        return $urandom_range(0, 1) ? sample_t'(int'(SAMPLE_MAX) - near)
                                    : sample_t'(int'(SAMPLE_MIN) + near);
    endfunction

    // All driving happens at the falling edge; handshakes are sampled at the
    // rising edge, before the block's own registers update.
    task automatic send_pixel(input pixel_in_t px);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = px;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_register(index, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stop offering, wait for every pending result, then let the pipe settle
    // so a register write never lands on a request in flight.
    task automatic wait_until_drained();
        s_valid = 1'b0;
        while (board.expected_pixels.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    // Receiver: random stall before each result; a long hold-off on request.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_data);
            @(negedge aclk);
        end
    end

    initial begin
        int        phase_len;
        int        pause_at;
        pixel_in_t px;
        board = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DIRECTION;
        cfg_data  = '0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        hold_off_request = 1'b0;
        pixels_sent      = 0;
        settings_used    = 0;

        // Corner pixels: both rails everywhere, alternating rails (sample_d
        // nonzero where it must be ignored), and -1 LSB, which lands exactly
        // on a half in the Bayer paths and checks ties round upward.
        corner_pixels[0] = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
        corner_pixels[1] = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
        corner_pixels[2] = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
        corner_pixels[3] = '{sample_t'(-1), sample_t'(0), sample_t'(0), sample_t'(0)};

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: each corner pixel under each of the six directed settings.
        for (int i = 0; i < 6; i++) begin
            wait_until_drained();
            write_register(CFG_DIRECTION, {1'b0, CORNER_DIRS[i]});
            write_register(CFG_CHANNEL_MODE, CORNER_MODES[i]);
            if (i == 2) begin
                // out-of-range index, the block must drop it
                write_register(CFG_SPARE_HI, MODE_UNUSED);
            end
            settings_used++;
            for (int v = 0; v < 4; v++) begin
                send_pixel(corner_pixels[v]);
            end
        end

        // Random phases, each with a fresh random setting. The first one
        // streams back to back into a long receiver hold-off so the pipeline
        // fills and s_ready drops; some phases stop halfway until the block
        // has returned everything.
        for (int phase = 0; pixels_sent < CORNER_COUNT + RANDOM_PIXELS; phase++) begin
            wait_until_drained();
            if ($urandom_range(0, 2) == 0) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                               CFG_DATA_BITS'($urandom));
            end
            // data bit 1 is don't-care for direction, still toggled
            write_register(CFG_DIRECTION, CFG_DATA_BITS'($urandom_range(0, 3)));
            write_register(CFG_CHANNEL_MODE, CFG_DATA_BITS'($urandom_range(0, 3)));
            settings_used++;
            gaps_on          = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            stalls_on        = ($urandom_range(0, 3) != 0);
            hold_off_request = (phase == 0) || ($urandom_range(0, 7) == 0);
            phase_len = $urandom_range(30, 150);
            pause_at  = (phase == 1 || $urandom_range(0, 3) == 0) ? phase_len / 2 : -1;
            for (int n = 0; n < phase_len; n++) begin
                if (n == pause_at) begin
                    s_valid = 1'b0;
                    while (board.expected_pixels.size() != 0) @(negedge aclk);
                end
                px.sample_a = random_sample();
                px.sample_b = random_sample();
                px.sample_c = random_sample();
                px.sample_d = random_sample();
                send_pixel(px);
            end
        end

        wait_until_drained();
        repeat (2 * PIPE_LATENCY) @(negedge aclk);

        $display("covered %0d pixels over %0d register settings: both directions,",
                 pixels_sent, settings_used);
        $display("all mode codes, dropped index writes; %0d results, %0d clipped, %0d bad",
                 board.checked, board.clipped, board.failures);
        if (board.failures == 0 && board.expected_pixels.size() == 0) begin
            $display("orthonormal_color_transform_tb: done, clean");
        end else begin
            $display("orthonormal_color_transform_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("timeout waiting for the block");
        $display("orthonormal_color_transform_tb: done, errors");
        $finish;
    end

endmodule
